FILE: rtl/cll_pkg.sv
// Shared types, codes and constants for the cursor linked list engine.
package cll_pkg;

  localparam int SLOTS_DEF       = 32;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int ACTION_W = 3;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int LIMIT_W  = 6;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic [ACTION_W-1:0] ACT_INS_AFTER = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_HEAD  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PREV      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_NEXT      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_FETCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic link;
    logic fetch;
    logic load;
  } cmd_t;

endpackage

FILE: rtl/cll_ctrl.sv
// Sequencing state machine for the cursor linked list engine.
module cll_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output cll_pkg::cmd_t cmd
);
  import cll_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC:  state_next = S_LINK;
      S_LINK:  state_next = S_FETCH;
      S_FETCH: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      S_EXEC:  cmd.exec  = 1'b1;
      S_LINK:  cmd.link  = 1'b1;
      S_FETCH: cmd.fetch = 1'b1;
      S_DONE:  cmd.load  = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

FILE: rtl/cll_dp.sv
// Datapath of the cursor linked list engine: link and payload memories, list state.
module cll_dp #(
  parameter int SLOTS       = cll_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = cll_pkg::HANDLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cll_pkg::cmd_t               cmd,
  input  logic [cll_pkg::IN_W-1:0]    in_data,
  input  logic                        cfg_we,
  input  logic [cll_pkg::LIMIT_W-1:0] cfg_wdata,
  output logic [cll_pkg::OUT_W-1:0]   out_data
);
  import cll_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int PW   = $clog2(SLOTS + 1);
  localparam int HW   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int CMPW = (PW > LIMIT_W) ? PW : LIMIT_W;
  localparam int PADW = OUT_W - STATUS_W - HANDLE_W - COUNT_W - 2;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  logic [PW-1:0] next_link [SLOTS];
  logic [PW-1:0] prev_link [SLOTS];
  logic [HW-1:0] payload   [SLOTS];

  logic [LIMIT_W-1:0]  limit;
  logic [ACTION_W-1:0] act;
  logic [HW-1:0]       hnd;
  logic [PW-1:0]       head;
  logic [PW-1:0]       cursor;
  logic [PW-1:0]       count;
  logic [SLOTS-1:0]    used;
  logic [PW-1:0]       free_slot;
  logic [PW-1:0]       cur0;
  logic [PW-1:0]       rd_next;
  logic [PW-1:0]       rd_prev;
  logic [HW-1:0]       pay_q;
  logic [STATUS_W-1:0] st;
  logic                w2_next_en;
  logic                w2_prev_en;
  logic [PW-1:0]       w2_prev_addr;

  logic [PW-1:0]       lowest;
  logic                full;
  logic                nonempty;
  logic [PW-1:0]       head_next;
  logic [PW-1:0]       cursor_next;
  logic [PW-1:0]       count_next;
  logic [SLOTS-1:0]    used_next;
  logic [STATUS_W-1:0] st_next;
  logic                w2_next_en_next;
  logic                w2_prev_en_next;
  logic [PW-1:0]       w2_prev_addr_next;
  logic                nl_we;
  logic [PW-1:0]       nl_addr;
  logic [PW-1:0]       nl_data;
  logic                pl_we;
  logic [PW-1:0]       pl_addr;
  logic [PW-1:0]       pl_data;
  logic                py_we;
  logic [PW-1:0]       new_head;
  logic [HANDLE_W-1:0] hval;

  always_comb begin
    lowest = NIL;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) lowest = PW'(i);
    end
  end

  assign full     = (CMPW'(count) >= CMPW'(limit)) || (count >= NIL);
  assign nonempty = (count != '0);
  assign new_head = (cursor == head) ? rd_next : head;

  always_comb begin
    head_next         = head;
    cursor_next       = cursor;
    count_next        = count;
    used_next         = used;
    st_next           = ST_DONE;
    w2_next_en_next   = 1'b0;
    w2_prev_en_next   = 1'b0;
    w2_prev_addr_next = rd_next;
    nl_we             = 1'b0;
    nl_addr           = free_slot;
    nl_data           = NIL;
    pl_we             = 1'b0;
    pl_addr           = free_slot;
    pl_data           = NIL;
    py_we             = 1'b0;
    if (cmd.link) begin
      nl_we   = w2_next_en;
      nl_addr = cur0;
      nl_data = free_slot;
      pl_we   = w2_prev_en;
      pl_addr = w2_prev_addr;
      pl_data = free_slot;
    end else if (cmd.exec) begin
      case (act)
        ACT_INS_AFTER, ACT_INS_HEAD: begin
          if (full) begin
            st_next = ST_FULL;
          end else begin
            used_next[free_slot[SW-1:0]] = 1'b1;
            py_we      = 1'b1;
            count_next = count + PW'(1);
            nl_we      = 1'b1;
            pl_we      = 1'b1;
            if (!nonempty) begin
              head_next   = free_slot;
              cursor_next = free_slot;
            end else if (act == ACT_INS_HEAD) begin
              nl_data           = head;
              head_next         = free_slot;
              w2_prev_en_next   = 1'b1;
              w2_prev_addr_next = head;
            end else begin
              nl_data         = rd_next;
              pl_data         = cursor;
              w2_next_en_next = 1'b1;
              w2_prev_en_next = (rd_next < NIL);
            end
          end
        end
        ACT_DELETE: begin
          if (!nonempty) begin
            st_next = ST_EMPTY;
          end else begin
            nl_we     = (rd_prev < NIL);
            nl_addr   = rd_prev;
            nl_data   = rd_next;
            pl_we     = (rd_next < NIL);
            pl_addr   = rd_next;
            pl_data   = rd_prev;
            head_next = new_head;
            cursor_next = (rd_next < NIL) ? rd_next : new_head;
            used_next[cursor[SW-1:0]] = 1'b0;
            count_next = count - PW'(1);
            if (count == PW'(1)) begin
              head_next   = NIL;
              cursor_next = NIL;
            end
          end
        end
        ACT_PREV: begin
          if (!nonempty) begin
            st_next = ST_EMPTY;
          end else if (count == PW'(1) || cursor == head || !(rd_prev < NIL)) begin
            st_next = ST_END;
          end else begin
            cursor_next = rd_prev;
          end
        end
        ACT_NEXT: begin
          if (!nonempty) begin
            st_next = ST_EMPTY;
          end else if (count == PW'(1) || !(rd_next < NIL)) begin
            st_next = ST_END;
          end else begin
            cursor_next = rd_next;
          end
        end
        default: st_next = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (nl_we) next_link[nl_addr[SW-1:0]] <= nl_data;
    if (pl_we) prev_link[pl_addr[SW-1:0]] <= pl_data;
    if (py_we) payload[free_slot[SW-1:0]] <= hnd;
    if (cmd.accept) begin
      rd_next <= next_link[cursor[SW-1:0]];
      rd_prev <= prev_link[cursor[SW-1:0]];
    end
    if (cmd.fetch) pay_q <= payload[cursor[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act       <= in_data[ACTION_W-1:0];
      hnd       <= in_data[ACTION_W +: HW];
      free_slot <= lowest;
      cur0      <= cursor;
    end
    if (cmd.exec) begin
      st           <= st_next;
      w2_prev_addr <= w2_prev_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= LIMIT_RESET;
      head       <= NIL;
      cursor     <= NIL;
      count      <= '0;
      used       <= '0;
      w2_next_en <= 1'b0;
      w2_prev_en <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (cmd.exec) begin
        head       <= head_next;
        cursor     <= cursor_next;
        count      <= count_next;
        used       <= used_next;
        w2_next_en <= w2_next_en_next;
        w2_prev_en <= w2_prev_en_next;
      end
    end
  end

  assign hval = nonempty ? HANDLE_W'(pay_q) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= {{PADW{1'b0}}, full, !nonempty, COUNT_W'(count), hval, st};
    end
  end

endmodule

FILE: rtl/cursor_linked_list_engine.sv
// Top level of the cursor linked list engine.
//
// Command items arrive on the s_ channel: tdata holds action in bits [2:0]
// and song_handle in bits [18:3]. Each item gives exactly one result item on
// the m_ channel: status [1:0], current_handle [17:2], list_count [23:18],
// list_empty [24], list_full [25].
// cfg_we with cfg_wdata writes the capacity limit; write only while idle.
// An item is taken, then runs through execute, link write-back and payload
// fetch before its result is registered. One item is in work at a time, so
// a new item is taken only once the previous result is loaded. Link write-back
// serves the single write port of each link memory (an insert writes one twice).
// The result sits in an output register: a stalled receiver holds the
// engine in its final step only once a second result is ready.
// Reset (rst, synchronous) empties the list, sets head and cursor to null
// and the capacity limit to 32; link and payload memories are not cleared.
module cursor_linked_list_engine #(
  parameter int SLOTS       = cll_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = cll_pkg::HANDLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [cll_pkg::IN_W-1:0]    s_tdata,   // action, song_handle
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [cll_pkg::OUT_W-1:0]   m_tdata,   // status, current_handle, list_count,
                                                 // list_empty, list_full
  input  logic                        cfg_we,
  input  logic [cll_pkg::LIMIT_W-1:0] cfg_wdata
);
  import cll_pkg::*;

  cmd_t cmd;

  cll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  cll_dp #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in work");

  a_empty_handle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[24]) |-> (m_tdata[17:2] == '0))
    else $error("empty list reports a nonzero handle");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[24]) |-> (m_tdata[1:0] != ST_END))
    else $error("empty list reports list end");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load) |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule
